FILE: sv/rmrm_pkg.sv
`timescale 1ns / 1ps
// Package for the request merge run monitor: widths, request kinds,
// statistic indices and the structs passed between the modules. No dependencies.
package rmrm_pkg;

    localparam int COUNT_WIDTH  = 32;
    localparam int RUN_WIDTH    = 16;
    localparam int HIST_BUCKETS = 6;
    localparam int NUM_STATS    = 16;
    localparam int STAT_IDX_W   = $clog2(NUM_STATS);

    // Output field widths are fixed by the interface.
    localparam int VALUE_W  = 32;
    localparam int CLOSED_W = 16;

    // Width that holds any counter or run length plus a carry.
    localparam int WIDE_W = ((COUNT_WIDTH > RUN_WIDTH) ? COUNT_WIDTH : RUN_WIDTH) + 1;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [RUN_WIDTH-1:0]   t_run;
    typedef logic [STAT_IDX_W-1:0]  t_stat_idx;

    // Request kinds; the remaining codes are ignored.
    localparam logic [2:0] KIND_TEX   = 3'd0;
    localparam logic [2:0] KIND_OTHER = 3'd1;
    localparam logic [2:0] KIND_BAR   = 3'd2;
    localparam logic [2:0] KIND_FLUSH = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // Statistic indices.
    localparam t_stat_idx ST_TEX     = 4'd0;
    localparam t_stat_idx ST_RUNS    = 4'd1;
    localparam t_stat_idx ST_SAVED   = 4'd2;
    localparam t_stat_idx ST_LONGEST = 4'd3;
    localparam t_stat_idx ST_ORIGIN  = 4'd4;
    localparam t_stat_idx ST_OTHER   = 4'd5;
    localparam t_stat_idx ST_HIST    = 4'd6;
    localparam t_stat_idx ST_BRK_RES = 4'd12;
    localparam t_stat_idx ST_BRK_SUB = 4'd13;
    localparam t_stat_idx ST_BRK_SRC = 4'd14;
    localparam t_stat_idx ST_BRK_BAR = 4'd15;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] resource_handle;
        logic [31:0] subresource;
        logic        from_memory;
        logic [31:0] source_file;
        logic [63:0] source_start;
        logic [31:0] source_size;
        logic [31:0] box_left;
        logic [31:0] box_top;
        logic [31:0] box_front;
        logic [3:0]  counter_index;
    } t_req;

    typedef struct packed {
        logic [31:0] counter_value;
        logic        run_closed;
        logic [15:0] closed_length;
        logic        run_continued;
    } t_res;

    // Events of one request, from the run tracker to the statistics.
    typedef struct packed {
        logic tex;
        logic origin;
        logic other;
        logic brk_res;
        logic brk_sub;
        logic brk_src;
        logic brk_bar;
        logic close;
        t_run close_len;
    } t_run_evt;

endpackage

FILE: sv/rmrm_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying one request.
// Depends on rmrm_pkg.
interface rmrm_req_if;
    logic          valid;
    logic          ready;
    rmrm_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/rmrm_res_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one result.
// Depends on rmrm_pkg.
interface rmrm_res_if;
    logic          valid;
    logic          ready;
    rmrm_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/rmrm_run_tracker.sv
`timescale 1ns / 1ps
// Run tracker: holds the open run and decides continue, break and close
// for each request. Depends on rmrm_pkg.
module rmrm_run_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  rmrm_pkg::t_req     i_req,
    output rmrm_pkg::t_run_evt o_evt,
    output logic               o_continued
);

    rmrm_pkg::t_run r_run_len, n_run_len;
    logic [31:0]    r_last_res, n_last_res;
    logic [31:0]    r_last_sub, n_last_sub;
    logic           r_last_mem, n_last_mem;
    logic [31:0]    r_last_file, n_last_file;
    logic [63:0]    r_exp_end, n_exp_end;

    logic run_open;
    logic same_res;
    logic sub_ok;
    logic src_ok;
    logic cont;

    assign run_open = (r_run_len != '0);
    assign same_res = run_open && (i_req.resource_handle == r_last_res)
                      && (i_req.from_memory == r_last_mem);
    assign sub_ok   = (i_req.subresource == r_last_sub + 32'd1);
    assign src_ok   = (i_req.source_start == r_exp_end)
                      && (i_req.from_memory || (i_req.source_file == r_last_file));

    always_comb begin
        o_evt       = '0;
        cont        = 1'b0;
        n_run_len   = r_run_len;
        n_last_res  = r_last_res;
        n_last_sub  = r_last_sub;
        n_last_mem  = r_last_mem;
        n_last_file = r_last_file;
        n_exp_end   = r_exp_end;
        unique case (i_req.kind)
            rmrm_pkg::KIND_TEX: begin
                cont          = same_res && sub_ok && src_ok;
                o_evt.tex     = 1'b1;
                o_evt.origin  = (i_req.box_left == '0) && (i_req.box_top == '0)
                                && (i_req.box_front == '0);
                o_evt.brk_res = run_open && !same_res;
                o_evt.brk_sub = same_res && !sub_ok;
                o_evt.brk_src = same_res && sub_ok && !src_ok;
                o_evt.close   = run_open && !cont;
                n_last_res    = i_req.resource_handle;
                n_last_sub    = i_req.subresource;
                n_last_mem    = i_req.from_memory;
                if (!i_req.from_memory) begin
                    n_last_file = i_req.source_file;
                end
                n_exp_end     = i_req.source_start + 64'(i_req.source_size);
                if (!cont) begin
                    n_run_len = rmrm_pkg::RUN_WIDTH'(1);
                end else if (r_run_len != '1) begin
                    n_run_len = r_run_len + rmrm_pkg::RUN_WIDTH'(1);
                end
            end
            rmrm_pkg::KIND_OTHER, rmrm_pkg::KIND_BAR, rmrm_pkg::KIND_FLUSH: begin
                o_evt.other   = (i_req.kind == rmrm_pkg::KIND_OTHER);
                o_evt.brk_bar = (i_req.kind == rmrm_pkg::KIND_BAR)
                                && (r_run_len > rmrm_pkg::RUN_WIDTH'(1));
                o_evt.close   = run_open;
                if (run_open) begin
                    n_run_len  = '0;
                    n_last_res = '0;
                end
            end
            default: begin
                // counter read and unused codes leave the run alone
            end
        endcase
        o_evt.close_len = o_evt.close ? r_run_len : '0;
    end

    assign o_continued = cont;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_len   <= '0;
            r_last_res  <= '0;
            r_last_sub  <= '0;
            r_last_mem  <= 1'b0;
            r_last_file <= '0;
            r_exp_end   <= '0;
        end else if (i_fire) begin
            r_run_len   <= n_run_len;
            r_last_res  <= n_last_res;
            r_last_sub  <= n_last_sub;
            r_last_mem  <= n_last_mem;
            r_last_file <= n_last_file;
            r_exp_end   <= n_exp_end;
        end
    end

    a_tex_opens_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_req.kind == rmrm_pkg::KIND_TEX |=> r_run_len != '0)
        else $error("texture request left no open run");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_req.kind == rmrm_pkg::KIND_OTHER || i_req.kind == rmrm_pkg::KIND_BAR
                   || i_req.kind == rmrm_pkg::KIND_FLUSH)
        |=> r_run_len == '0 && r_last_res == '0)
        else $error("run not cleared after close");

    a_one_break: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_evt.brk_res, o_evt.brk_sub, o_evt.brk_src, o_evt.brk_bar}) <= 1)
        else $error("more than one break cause in one request");

endmodule

FILE: sv/rmrm_stats.sv
`timescale 1ns / 1ps
// Statistics: sixteen saturating counters updated from run events, with
// an index read port. Depends on rmrm_pkg.
module rmrm_stats (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  rmrm_pkg::t_run_evt  i_evt,
    input  rmrm_pkg::t_stat_idx i_rd_idx,
    output rmrm_pkg::t_count    o_rd_value
);

    localparam logic [rmrm_pkg::WIDE_W-1:0] CountMax =
        rmrm_pkg::WIDE_W'({rmrm_pkg::COUNT_WIDTH{1'b1}});

    rmrm_pkg::t_count r_stat [rmrm_pkg::NUM_STATS];
    rmrm_pkg::t_count n_stat [rmrm_pkg::NUM_STATS];

    logic [rmrm_pkg::NUM_STATS-1:0] inc;
    rmrm_pkg::t_stat_idx            hist_idx;
    logic [rmrm_pkg::WIDE_W-1:0]    saved_sum;
    logic [rmrm_pkg::WIDE_W-1:0]    len_w;

    // Buckets: 1, 2, 3-4, 5-8, 9-16, 17 and more.
    always_comb begin
        priority if (i_evt.close_len == rmrm_pkg::RUN_WIDTH'(1)) begin
            hist_idx = rmrm_pkg::ST_HIST;
        end else if (i_evt.close_len == rmrm_pkg::RUN_WIDTH'(2)) begin
            hist_idx = rmrm_pkg::ST_HIST + rmrm_pkg::STAT_IDX_W'(1);
        end else if (i_evt.close_len <= rmrm_pkg::RUN_WIDTH'(4)) begin
            hist_idx = rmrm_pkg::ST_HIST + rmrm_pkg::STAT_IDX_W'(2);
        end else if (i_evt.close_len <= rmrm_pkg::RUN_WIDTH'(8)) begin
            hist_idx = rmrm_pkg::ST_HIST + rmrm_pkg::STAT_IDX_W'(3);
        end else if (i_evt.close_len <= rmrm_pkg::RUN_WIDTH'(16)) begin
            hist_idx = rmrm_pkg::ST_HIST + rmrm_pkg::STAT_IDX_W'(4);
        end else begin
            hist_idx = rmrm_pkg::ST_HIST
                       + rmrm_pkg::STAT_IDX_W'(rmrm_pkg::HIST_BUCKETS - 1);
        end
    end

    assign len_w     = rmrm_pkg::WIDE_W'(i_evt.close_len);
    assign saved_sum = rmrm_pkg::WIDE_W'(r_stat[rmrm_pkg::ST_SAVED])
                       + len_w - rmrm_pkg::WIDE_W'(1);

    always_comb begin
        inc                        = '0;
        inc[rmrm_pkg::ST_TEX]      = i_evt.tex;
        inc[rmrm_pkg::ST_ORIGIN]   = i_evt.origin;
        inc[rmrm_pkg::ST_OTHER]    = i_evt.other;
        inc[rmrm_pkg::ST_BRK_RES]  = i_evt.brk_res;
        inc[rmrm_pkg::ST_BRK_SUB]  = i_evt.brk_sub;
        inc[rmrm_pkg::ST_BRK_SRC]  = i_evt.brk_src;
        inc[rmrm_pkg::ST_BRK_BAR]  = i_evt.brk_bar;
        inc[rmrm_pkg::ST_RUNS]     = i_evt.close;
        inc[hist_idx]              = inc[hist_idx] | i_evt.close;
    end

    always_comb begin
        for (int i = 0; i < rmrm_pkg::NUM_STATS; i++) begin
            n_stat[i] = r_stat[i];
            if (inc[i] && r_stat[i] != '1) begin
                n_stat[i] = r_stat[i] + rmrm_pkg::COUNT_WIDTH'(1);
            end
        end
        if (i_evt.close) begin
            n_stat[rmrm_pkg::ST_SAVED] = (saved_sum > CountMax)
                ? '1 : rmrm_pkg::COUNT_WIDTH'(saved_sum);
            if (len_w > rmrm_pkg::WIDE_W'(r_stat[rmrm_pkg::ST_LONGEST])) begin
                n_stat[rmrm_pkg::ST_LONGEST] = (len_w > CountMax)
                    ? '1 : rmrm_pkg::COUNT_WIDTH'(len_w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rmrm_pkg::NUM_STATS; i++) begin
                r_stat[i] <= '0;
            end
        end else if (i_fire) begin
            for (int i = 0; i < rmrm_pkg::NUM_STATS; i++) begin
                r_stat[i] <= n_stat[i];
            end
        end
    end

    assign o_rd_value = r_stat[i_rd_idx];

    a_runs_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_evt.close && r_stat[rmrm_pkg::ST_RUNS] != '1
        |=> r_stat[rmrm_pkg::ST_RUNS] == $past(r_stat[rmrm_pkg::ST_RUNS])
            + rmrm_pkg::COUNT_WIDTH'(1))
        else $error("closed run not counted");

    a_longest_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 r_stat[rmrm_pkg::ST_LONGEST] >= $past(r_stat[rmrm_pkg::ST_LONGEST]))
        else $error("longest run decreased");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_stat[rmrm_pkg::ST_TEX]) && $stable(r_stat[rmrm_pkg::ST_SAVED]))
        else $error("statistics moved without a request");

endmodule

FILE: sv/request_merge_run_monitor_core.sv
`timescale 1ns / 1ps
// Request merge run monitor, top level. Takes one request per cycle and
// returns one result per request; a request is registered on transfer, and
// its run decision and counter updates are made when it advances from the
// input register and are written to the result register; a new request can be
// taken every cycle while the result side keeps up. Sixteen saturating
// statistics are read by a counter-read request that reports the counts
// with every earlier request included. Depends on rmrm_pkg, the channel
// interfaces, rmrm_run_tracker and rmrm_stats.
module request_merge_run_monitor_core (
    input logic         i_clk,
    input logic         i_rst_n,
    rmrm_req_if.sink    i_req,
    rmrm_res_if.source  o_res
);

    logic             r_in_valid;
    rmrm_pkg::t_req   r_in;
    logic             r_out_valid;
    rmrm_pkg::t_res   r_out;
    rmrm_pkg::t_res   n_out;

    logic               adv;
    rmrm_pkg::t_run_evt evt;
    logic               continued;
    rmrm_pkg::t_count   rd_value;
    logic [63:0]        rd_wide;
    logic [31:0]        len_wide;

    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || adv;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    rmrm_run_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (adv),
        .i_req       (r_in),
        .o_evt       (evt),
        .o_continued (continued)
    );

    rmrm_stats u_stats (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (adv),
        .i_evt      (evt),
        .i_rd_idx   (r_in.counter_index),
        .o_rd_value (rd_value)
    );

    assign rd_wide  = 64'(rd_value);
    assign len_wide = 32'(evt.close_len);

    always_comb begin
        n_out               = '0;
        n_out.counter_value = (r_in.kind == rmrm_pkg::KIND_READ)
                              ? rd_wide[rmrm_pkg::VALUE_W-1:0] : '0;
        n_out.run_closed    = evt.close;
        n_out.closed_length = len_wide[rmrm_pkg::CLOSED_W-1:0];
        n_out.run_continued = continued;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    a_close_xor_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.run_closed && r_out.run_continued))
        else $error("result both closed and continued a run");

    a_value_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.kind != rmrm_pkg::KIND_READ |=> r_out.counter_value == '0)
        else $error("counter value on a non-read request");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in))
        else $error("stalled request lost");

endmodule
